// ===== sv/tsplib_node_distance_unit_assert.svh =====
// assertion macros for the node distance unit
`ifndef TSPLIB_NODE_DISTANCE_UNIT_ASSERT_SVH
`define TSPLIB_NODE_DISTANCE_UNIT_ASSERT_SVH

// same-cycle implication
`define TND_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("node distance check failed");

// next-cycle implication
`define TND_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("node distance check failed");

`endif

// ===== sv/tnd_pkg.sv =====
// shared constants for the node distance unit
package tnd_pkg;

    localparam int NODE_COUNT  = 1024;
    localparam int ADDR_W      = $clog2(NODE_COUNT);
    localparam int NODE_W      = 10;
    localparam int COORD_W     = 32;
    localparam int ENTRY_W     = 2 * COORD_W;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SUM_W       = 2 * DIFF_W;
    localparam int FRAC_SQ_W   = 16;
    localparam int Q_W         = SUM_W - FRAC_SQ_W;
    localparam int DIV_STEP    = 5;
    localparam int DIV_STAGES  = Q_W / DIV_STEP;
    localparam int DREM_W      = 4;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int REM_W       = ROOT_W + 2;
    localparam int DIST_W      = 25;
    localparam int MODE_W      = 2;

    localparam logic [MODE_W-1:0] MODE_ROUND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CEIL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ATT   = 2'd2;

    localparam logic [0:0] REQ_LOAD  = 1'b0;
    localparam logic [0:0] REQ_QUERY = 1'b1;

    localparam logic [DREM_W:0] TEN = 5'd10;

endpackage

// ===== sv/tnd_req_if.sv =====
// request channel interface
interface tnd_req_if;
    logic                            valid;
    logic                            ready;
    logic [0:0]                      req_type;
    logic [tnd_pkg::NODE_W-1:0]      node_a;
    logic [tnd_pkg::NODE_W-1:0]      node_b;
    logic signed [tnd_pkg::COORD_W-1:0] coord_x;
    logic signed [tnd_pkg::COORD_W-1:0] coord_y;

    modport source (output valid, req_type, node_a, node_b, coord_x, coord_y, input ready);
    modport sink (input valid, req_type, node_a, node_b, coord_x, coord_y, output ready);
endinterface

// ===== sv/tnd_rsp_if.sv =====
// response channel interface
interface tnd_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tnd_pkg::DIST_W-1:0]  node_distance;

    modport source (output valid, node_distance, input ready);
    modport sink (input valid, node_distance, output ready);
endinterface

// ===== sv/tnd_ram.sv =====
// generic single write, single read ram with registered read
module tnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tnd_div10.sv =====
// pipelined ceiling of the squared sum over 655360
module tnd_div10 (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [tnd_pkg::SUM_W-1:0]    in_sum,
    output logic                         out_valid,
    output logic [tnd_pkg::SUM_W-1:0]    out_sum,
    output logic [tnd_pkg::Q_W-1:0]      out_quot
);

    localparam int NS = tnd_pkg::DIV_STAGES;

    logic                         v_reg   [NS+1];
    logic [tnd_pkg::SUM_W-1:0]    sum_reg [NS+1];
    logic [tnd_pkg::Q_W-1:0]      dvd_reg [NS+1];
    logic [tnd_pkg::DREM_W-1:0]   rem_reg [NS+1];
    logic [tnd_pkg::Q_W-1:0]      dvd_next;

    // ceil of sum / 65536, plus nine for the ceiling of the division
    always_comb
    begin
        dvd_next = in_sum[tnd_pkg::SUM_W-1:tnd_pkg::FRAC_SQ_W]
                 + tnd_pkg::Q_W'(|in_sum[tnd_pkg::FRAC_SQ_W-1:0])
                 + tnd_pkg::Q_W'(9);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg[0] <= in_sum;
            dvd_reg[0] <= dvd_next;
            rem_reg[0] <= '0;
        end
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        logic [tnd_pkg::Q_W-1:0]    dvd_c;
        logic [tnd_pkg::DREM_W-1:0] rem_c;

        // restoring division by ten, several quotient bits per stage
        always_comb
        begin
            logic [tnd_pkg::DREM_W:0] cand;
            dvd_c = dvd_reg[g];
            rem_c = rem_reg[g];
            for (int k = 0; k < tnd_pkg::DIV_STEP; k++)
            begin
                cand = {rem_c, dvd_c[tnd_pkg::Q_W-1]};
                if (cand >= tnd_pkg::TEN)
                begin
                    rem_c = tnd_pkg::DREM_W'(cand - tnd_pkg::TEN);
                    dvd_c = {dvd_c[tnd_pkg::Q_W-2:0], 1'b1};
                end
                else
                begin
                    rem_c = cand[tnd_pkg::DREM_W-1:0];
                    dvd_c = {dvd_c[tnd_pkg::Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g+1] <= v_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sum_reg[g+1] <= sum_reg[g];
                dvd_reg[g+1] <= dvd_c;
                rem_reg[g+1] <= rem_c;
            end
        end
    end

    assign out_valid = v_reg[NS];
    assign out_sum   = sum_reg[NS];
    assign out_quot  = dvd_reg[NS];

endmodule

// ===== sv/tnd_isqrt.sv =====
// pipelined integer square root, one root bit per stage
module tnd_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [tnd_pkg::SUM_W-1:0]     in_op,
    output logic                          out_valid,
    output logic [tnd_pkg::ROOT_W-1:0]    out_root,
    output logic                          out_inexact
);

    localparam int NS = tnd_pkg::ROOT_W;

    logic                          v_reg    [NS+1];
    logic [tnd_pkg::SUM_W-1:0]     op_reg   [NS+1];
    logic [tnd_pkg::REM_W-1:0]     rem_reg  [NS+1];
    logic [tnd_pkg::ROOT_W-1:0]    root_reg [NS+1];

    assign v_reg[0]    = in_valid;
    assign op_reg[0]   = in_op;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        logic [tnd_pkg::REM_W-1:0]  rem_c;
        logic [tnd_pkg::ROOT_W-1:0] root_c;

        always_comb
        begin
            logic [tnd_pkg::REM_W+1:0] cand;
            logic [tnd_pkg::REM_W+1:0] trial;
            cand  = {rem_reg[g], op_reg[g][tnd_pkg::SUM_W-1 -: 2]};
            trial = (tnd_pkg::REM_W+2)'({root_reg[g], 2'b01});
            if (cand >= trial)
            begin
                rem_c  = tnd_pkg::REM_W'(cand - trial);
                root_c = {root_reg[g][tnd_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_c  = cand[tnd_pkg::REM_W-1:0];
                root_c = {root_reg[g][tnd_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g+1] <= v_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                op_reg[g+1]   <= {op_reg[g][tnd_pkg::SUM_W-3:0], 2'b00};
                rem_reg[g+1]  <= rem_c;
                root_reg[g+1] <= root_c;
            end
        end
    end

    assign out_valid   = v_reg[NS];
    assign out_root    = root_reg[NS];
    assign out_inexact = |rem_reg[NS];

endmodule

// ===== sv/tsplib_node_distance_unit.sv =====
// Node distance unit: loads write one node's coordinates into a 1024-entry table held in two
// copies of a block ram (one per query operand), queries return the TSPLIB distance in the
// mode held in metric_mode. One request is taken every cycle while the response side takes
// results; a load finishes at its acceptance edge and a query's distance is registered through
// the ram read, difference, square, sum, divider input register, ten divide-by-ten stages,
// a 33-stage root and the output register. A stalled response holds the whole pipeline, and
// the request side with it.
module tsplib_node_distance_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         metric_mode_we,
    input  logic [tnd_pkg::MODE_W-1:0]   metric_mode_wdata,
    tnd_req_if.sink                      req,
    tnd_rsp_if.source                    rsp
);

    logic [tnd_pkg::MODE_W-1:0]  mode_reg;
    logic                        en;
    logic                        req_acc;
    logic                        load_we;
    logic                        in_a;
    logic                        in_b;
    logic [tnd_pkg::ENTRY_W-1:0] ent_a;
    logic [tnd_pkg::ENTRY_W-1:0] ent_b;

    logic                        v1_reg, v2_reg, v3_reg, v4_reg;
    logic                        oob_a_reg, oob_b_reg;
    logic [tnd_pkg::DIFF_W-1:0]  dx_reg, dy_reg, dx_next, dy_next;
    logic [tnd_pkg::SUM_W-1:0]   sqx_reg, sqy_reg, sum_reg;

    logic                        dv_valid;
    logic [tnd_pkg::SUM_W-1:0]   dv_sum;
    logic [tnd_pkg::Q_W-1:0]     dv_quot;
    logic [tnd_pkg::SUM_W-1:0]   sq_op;
    logic                        sq_valid;
    logic [tnd_pkg::ROOT_W-1:0]  sq_root;
    logic                        sq_inexact;

    logic                        out_valid_reg;
    logic [tnd_pkg::DIST_W-1:0]  dist_reg, dist_next;

    assign en        = !(out_valid_reg && !rsp.ready);
    assign req.ready = en;
    assign req_acc   = req.valid && en;
    assign in_a      = 32'(req.node_a) < tnd_pkg::NODE_COUNT;
    assign in_b      = 32'(req.node_b) < tnd_pkg::NODE_COUNT;
    assign load_we   = req_acc && (req.req_type == tnd_pkg::REQ_LOAD) && in_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tnd_pkg::MODE_ROUND;
        end
        else if (metric_mode_we)
        begin
            mode_reg <= metric_mode_wdata;
        end
    end

    tnd_ram #(.WIDTH(tnd_pkg::ENTRY_W), .DEPTH(tnd_pkg::NODE_COUNT)) u_ram_a (
        .clk   (clk),
        .we    (load_we),
        .waddr (tnd_pkg::ADDR_W'(req.node_a)),
        .wdata ({req.coord_x, req.coord_y}),
        .re    (en),
        .raddr (tnd_pkg::ADDR_W'(req.node_a)),
        .rdata (ent_a)
    );

    tnd_ram #(.WIDTH(tnd_pkg::ENTRY_W), .DEPTH(tnd_pkg::NODE_COUNT)) u_ram_b (
        .clk   (clk),
        .we    (load_we),
        .waddr (tnd_pkg::ADDR_W'(req.node_a)),
        .wdata ({req.coord_x, req.coord_y}),
        .re    (en),
        .raddr (tnd_pkg::ADDR_W'(req.node_b)),
        .rdata (ent_b)
    );

    // absolute coordinate differences, nodes outside the table read as origin
    always_comb
    begin
        logic [tnd_pkg::COORD_W-1:0] xa, ya, xb, yb;
        logic signed [tnd_pkg::DIFF_W-1:0] ddx, ddy;
        xa = oob_a_reg ? '0 : ent_a[tnd_pkg::ENTRY_W-1:tnd_pkg::COORD_W];
        ya = oob_a_reg ? '0 : ent_a[tnd_pkg::COORD_W-1:0];
        xb = oob_b_reg ? '0 : ent_b[tnd_pkg::ENTRY_W-1:tnd_pkg::COORD_W];
        yb = oob_b_reg ? '0 : ent_b[tnd_pkg::COORD_W-1:0];
        ddx = $signed({xa[tnd_pkg::COORD_W-1], xa}) - $signed({xb[tnd_pkg::COORD_W-1], xb});
        ddy = $signed({ya[tnd_pkg::COORD_W-1], ya}) - $signed({yb[tnd_pkg::COORD_W-1], yb});
        dx_next = ddx[tnd_pkg::DIFF_W-1] ? tnd_pkg::DIFF_W'(-ddx) : tnd_pkg::DIFF_W'(ddx);
        dy_next = ddy[tnd_pkg::DIFF_W-1] ? tnd_pkg::DIFF_W'(-ddy) : tnd_pkg::DIFF_W'(ddy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= req_acc && (req.req_type == tnd_pkg::REQ_QUERY);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oob_a_reg <= !in_a;
            oob_b_reg <= !in_b;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            sqx_reg   <= tnd_pkg::SUM_W'(dx_reg) * tnd_pkg::SUM_W'(dx_reg);
            sqy_reg   <= tnd_pkg::SUM_W'(dy_reg) * tnd_pkg::SUM_W'(dy_reg);
            sum_reg   <= sqx_reg + sqy_reg;
        end
    end

    tnd_div10 u_div10 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_sum    (sum_reg),
        .out_valid (dv_valid),
        .out_sum   (dv_sum),
        .out_quot  (dv_quot)
    );

    assign sq_op = (mode_reg == tnd_pkg::MODE_ATT) ? tnd_pkg::SUM_W'(dv_quot) : dv_sum;

    tnd_isqrt u_isqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (dv_valid),
        .in_op       (sq_op),
        .out_valid   (sq_valid),
        .out_root    (sq_root),
        .out_inexact (sq_inexact)
    );

    // final rounding per metric
    always_comb
    begin
        logic [tnd_pkg::ROOT_W+1:0] rc;
        logic [tnd_pkg::ROOT_W+1:0] rt;
        rc = (tnd_pkg::ROOT_W+2)'(sq_root) + (tnd_pkg::ROOT_W+2)'(sq_inexact);
        case (mode_reg)
            tnd_pkg::MODE_CEIL:
            begin
                rt = (rc + (tnd_pkg::ROOT_W+2)'(255)) >> 8;
            end
            tnd_pkg::MODE_ATT:
            begin
                rt = rc;
            end
            default:
            begin
                rt = ((tnd_pkg::ROOT_W+2)'(sq_root) + (tnd_pkg::ROOT_W+2)'(128)) >> 8;
            end
        endcase
        dist_next = rt[tnd_pkg::DIST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= dist_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.node_distance = dist_reg;

endmodule

// ===== sv/tnd_chk.sv =====
// port-level checks for the node distance unit
`include "tsplib_node_distance_unit_assert.svh"

module tnd_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [tnd_pkg::DIST_W-1:0]  node_distance
);

    `TND_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(node_distance))
    `TND_ASSERT_NOW(a_stall_backs_up, rsp_valid && !rsp_ready, !req_ready)
    `TND_ASSERT_NOW(a_dist_range, rsp_valid, node_distance <= 25'd23726567)

endmodule

bind tsplib_node_distance_unit tnd_chk u_tnd_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .node_distance (rsp.node_distance)
);
